/* rtl/brbf_pkg.sv */
package brbf_pkg;

    // Store geometry: capacity is DEPTH rounded up to a power of two.
    localparam int DEPTH  = 1024;
    localparam int LANES  = 8;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CAP    = 2 ** ADDR_W;
    localparam int PTR_W  = ADDR_W + 1;
    localparam int LANE_W = $clog2(LANES);
    localparam int ROW_W  = ADDR_W - LANE_W;
    localparam int ROWS   = CAP / LANES;
    localparam int CNT_W  = 4;
    localparam int DATA_W = 8 * LANES;

    // Operation codes carried in the func field.
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_PEEK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // Request details passed from the control logic to the merging stage.
    typedef struct packed {
        logic              ok;
        logic              rd;
        logic [LANE_W-1:0] rot;
        logic [CNT_W-1:0]  count;
    } req_t;

endpackage

/* rtl/brbf_bank.sv */
module brbf_bank (
    input  logic                       clk,
    input  logic                       we,
    input  logic [brbf_pkg::ROW_W-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic [brbf_pkg::ROW_W-1:0] raddr,
    output logic [7:0]                 rdata
);
    import brbf_pkg::*;

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    // One byte lane of the store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/brbf_merge.sv */
module brbf_merge (
    input  logic                                     clk,
    input  logic                                     load,
    input  brbf_pkg::req_t                           req,
    input  logic [brbf_pkg::LANES-1:0][7:0]          bank_rdata,
    output logic                                     ok,
    output logic [brbf_pkg::DATA_W-1:0]              read_data
);
    import brbf_pkg::*;

    logic [LANES-1:0][7:0] lane_data;
    logic [DATA_W-1:0]     read_data_reg;
    logic                  ok_reg;

    // Rotate the bank outputs so that the front byte lands in lane zero,
    // and clear every lane beyond the requested count, or every lane when no read is requested.
    always_comb
    begin
        logic [LANE_W-1:0] src;
        for (int i = 0; i < LANES; i++)
        begin
            src = req.rot + LANE_W'(i);
            if (req.rd && (CNT_W'(i) < req.count))
            begin
                lane_data[i] = bank_rdata[src];
            end
            else
            begin
                lane_data[i] = 8'h00;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            read_data_reg <= lane_data;
            ok_reg        <= req.ok;
        end
    end

    assign read_data = read_data_reg;
    assign ok        = ok_reg;

endmodule

/* rtl/byte_ring_buffer_fifo.sv */
// An operation is read from the byte lanes' registered port as it is transferred in,
// loaded into the result register in ST_READ and offered in ST_HOLD; no new
// operation is taken until that result is taken.
// Reset (rst_n, asynchronous, active low) empties the FIFO and idles the handshake.
// Store contents are not cleared; only bytes already written are ever returned.
module byte_ring_buffer_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [brbf_pkg::CNT_W-1:0]  count,
    input  logic [brbf_pkg::DATA_W-1:0] write_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [brbf_pkg::DATA_W-1:0] read_data,
    output logic [brbf_pkg::PTR_W-1:0]  used_count,
    output logic [brbf_pkg::PTR_W-1:0]  free_count
);
    import brbf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    req_t               req_reg, req_next;

    logic               accept;
    logic [PTR_W-1:0]   used;
    logic [PTR_W-1:0]   free;
    logic               is_clear, is_write, is_read, is_peek;
    logic               cnt_zero, cnt_big, op_ok, do_write;

    logic [LANES-1:0]             bank_we;
    logic [LANES-1:0][ROW_W-1:0]  bank_waddr;
    logic [LANES-1:0][7:0]        bank_wdata;
    logic [LANES-1:0][ROW_W-1:0]  bank_raddr;
    logic [LANES-1:0][7:0]        bank_rdata;

    assign accept = in_valid && in_ready;
    assign used   = wp_reg - rp_reg;
    assign free   = PTR_W'(CAP) - used;

    // Decode the operation and decide whether it can go ahead.
    always_comb
    begin
        is_clear = (func == FUNC_CLEAR);
        is_write = (func == FUNC_WRITE);
        is_read  = (func == FUNC_READ);
        is_peek  = (func == FUNC_PEEK);
        cnt_zero = (count == '0);
        cnt_big  = (count > CNT_W'(LANES));
        if (is_clear || cnt_zero)
        begin
            op_ok = 1'b1;
        end
        else if (cnt_big)
        begin
            op_ok = 1'b0;
        end
        else if (is_write)
        begin
            op_ok = (free >= PTR_W'(count));
        end
        else
        begin
            op_ok = (used >= PTR_W'(count));
        end
        do_write = accept && is_write && op_ok && !cnt_big;
    end

    // Pointer, request and state update.
    always_comb
    begin
        state_next = state_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        req_next   = req_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_READ;
                    req_next.ok    = op_ok;
                    req_next.rd    = op_ok && !cnt_big && (is_read || is_peek);
                    req_next.rot   = rp_reg[LANE_W-1:0];
                    req_next.count = count;
                    if (is_clear)
                    begin
                        rp_next = '0;
                        wp_next = '0;
                    end
                    else if (op_ok && !cnt_big)
                    begin
                        if (is_write)
                        begin
                            wp_next = wp_reg + PTR_W'(count);
                        end
                        else if (is_read)
                        begin
                            rp_next = rp_reg + PTR_W'(count);
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            req_reg   <= req_next;
        end
    end

    // Lane addressing: a bank below the pointer's lane takes the next row.
    always_comb
    begin
        logic [LANE_W-1:0] widx;
        for (int b = 0; b < LANES; b++)
        begin
            widx          = LANE_W'(b) - wp_reg[LANE_W-1:0];
            bank_we[b]    = do_write && (CNT_W'(widx) < count);
            bank_wdata[b] = write_data[8*widx +: 8];
            bank_waddr[b] = wp_reg[ADDR_W-1:LANE_W]
                          + ROW_W'(LANE_W'(b) < wp_reg[LANE_W-1:0]);
            bank_raddr[b] = rp_reg[ADDR_W-1:LANE_W]
                          + ROW_W'(LANE_W'(b) < rp_reg[LANE_W-1:0]);
        end
    end

    // Byte lanes of the circular store.
    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        brbf_bank u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_waddr[g]),
            .wdata (bank_wdata[g]),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    // Merge the lane outputs into the result.
    brbf_merge u_merge (
        .clk        (clk),
        .load       (state_reg == ST_READ),
        .req        (req_reg),
        .bank_rdata (bank_rdata),
        .ok         (ok),
        .read_data  (read_data)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_HOLD);
    assign used_count = used;
    assign free_count = free;

endmodule

/* rtl/brbf_checker.sv */
module brbf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [brbf_pkg::CNT_W-1:0]  count,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        ok,
    input  logic [brbf_pkg::DATA_W-1:0] read_data,
    input  logic [brbf_pkg::PTR_W-1:0]  used_count,
    input  logic [brbf_pkg::PTR_W-1:0]  free_count
);
    import brbf_pkg::*;

    // Used and free bytes add up to the capacity; checked whenever a result is offered.
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_count + free_count) == PTR_W'(CAP))
        else $error("used and free counts do not add up to the capacity");

    // A failed operation returns no data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> read_data == '0)
        else $error("failed operation returned data");

    // Every transfer in is followed first by a gap with no result offered, then by its result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid ##1 out_valid)
        else $error("result not offered two cycles after the transfer");

    // A clear succeeds and leaves the FIFO empty.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_CLEAR) |-> ##2 (ok && used_count == '0))
        else $error("clear did not empty the FIFO");

    // A result held back keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_data) && $stable(ok)))
        else $error("stalled result changed");

endmodule

bind byte_ring_buffer_fifo brbf_checker u_brbf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .count      (count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .read_data  (read_data),
    .used_count (used_count),
    .free_count (free_count)
);

/* tb/tb_top.sv */
module tb_top;

    import brbf_pkg::*;

    // Idling modes, cycled through in blocks of items.
    localparam int MODE_SPAN    = 40;
    localparam int RANDOM_ITEMS = 460;
    localparam int MIX_MIN      = 40;
    localparam int BRINK_ITEMS  = 15;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 20;
    localparam int LIMIT        = 200000;
    localparam int DIRECTED_N   = 25;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Where the random part steers the fill level.
    typedef enum int {
        TIDE_FILL,
        TIDE_DRAIN,
        TIDE_MIX
    } tide_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic [PTR_W-1:0]  used;
        logic [PTR_W-1:0]  free;
    } outcome_t;

    typedef struct packed {
        func_t             op;
        logic [CNT_W-1:0]  n;
        logic [DATA_W-1:0] wd;
        logic              typed;
        outcome_t          want;
    } stim_row_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    func_t             func       = FUNC_WRITE;
    logic [CNT_W-1:0]  count      = '0;
    logic [DATA_W-1:0] write_data = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [PTR_W-1:0]  used_count;
    logic [PTR_W-1:0]  free_count;

    // Shadow copy of the FIFO used to predict each outcome.
    logic [7:0]        shadow_bytes [CAP];
    logic [PTR_W-1:0]  shadow_rd = '0;
    logic [PTR_W-1:0]  shadow_wr = '0;

    outcome_t          awaited_outcomes [$];
    idle_mode_t        idle_mode = IDLE_NONE;
    int                mismatches = 0;
    int                cycle_count = 0;
    stim_row_t         directed_rows [DIRECTED_N];

    byte_ring_buffer_fifo dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .count      (count),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_data  (read_data),
        .used_count (used_count),
        .free_count (free_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Applies one operation to the shadow FIFO and returns its outcome.
    function automatic outcome_t compute_fifo_outcome(input func_t op,
                                                      input logic [CNT_W-1:0] n,
                                                      input logic [DATA_W-1:0] wd);
        outcome_t          res;
        logic [PTR_W-1:0]  level;
        logic [ADDR_W-1:0] addr;
        res = '0;
        level = shadow_wr - shadow_rd;
        if (op == FUNC_CLEAR)
        begin
            shadow_rd = '0;
            shadow_wr = '0;
            res.ok = 1'b1;
        end
        else if (n == 0)
        begin
            res.ok = 1'b1;
        end
        else if (n > LANES)
        begin
            res.ok = 1'b0;
        end
        else if (op == FUNC_WRITE)
        begin
            // All or nothing: the whole count must fit.
            if (CAP - level >= n)
            begin
                for (int i = 0; i < n; i++)
                begin
                    addr = shadow_wr[ADDR_W-1:0] + ADDR_W'(i);
                    shadow_bytes[addr] = wd[8*i +: 8];
                end
                shadow_wr = shadow_wr + PTR_W'(n);
                res.ok = 1'b1;
            end
        end
        else if (level >= n)
        begin
            // Read and peek gather from the front; only read consumes.
            for (int i = 0; i < n; i++)
            begin
                addr = shadow_rd[ADDR_W-1:0] + ADDR_W'(i);
                res.data[8*i +: 8] = shadow_bytes[addr];
            end
            if (op == FUNC_READ)
            begin
                shadow_rd = shadow_rd + PTR_W'(n);
            end
            res.ok = 1'b1;
        end
        res.used = shadow_wr - shadow_rd;
        res.free = PTR_W'(CAP) - res.used;
        return res;
    endfunction

    function automatic logic sender_idles();
        if (idle_mode == IDLE_SENDER)
        begin
            return $urandom_range(99) < 75;
        end
        if (idle_mode == IDLE_BOTH)
        begin
            return $urandom_range(99) < 36;
        end
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        if (idle_mode == IDLE_RECEIVER)
        begin
            return $urandom_range(99) < 75;
        end
        if (idle_mode == IDLE_BOTH)
        begin
            return $urandom_range(99) < 36;
        end
        return 1'b0;
    endfunction

    // Offers one operation, waits for its transfer, then records what should come back.
    task automatic issue_op(input func_t op, input logic [CNT_W-1:0] n,
                            input logic [DATA_W-1:0] wd, input logic typed,
                            input outcome_t want);
        outcome_t predicted;
        if (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (sender_idles())
            begin
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        func       <= op;
        count      <= n;
        write_data <= wd;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = compute_fifo_outcome(op, n, wd);
        if (typed)
        begin
            awaited_outcomes.push_back(want);
        end
        else
        begin
            awaited_outcomes.push_back(predicted);
        end
    endtask

    // Result side: check each transfer out, and stall as the current mode asks.
    initial
    begin
        int       hold_left;
        int       results_taken;
        outcome_t exp;
        hold_left = 0;
        results_taken = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result with nothing outstanding: ok %0b data %h", ok, read_data);
                    mismatches++;
                end
                else
                begin
                    exp = awaited_outcomes.pop_front();
                    if (ok !== exp.ok)
                    begin
                        $error("ok: expected %0b, actual %0b", exp.ok, ok);
                        mismatches++;
                    end
                    if (read_data !== exp.data)
                    begin
                        $error("read_data: expected %h, actual %h", exp.data, read_data);
                        mismatches++;
                    end
                    if (used_count !== exp.used)
                    begin
                        $error("used_count: expected %0d, actual %0d", exp.used, used_count);
                        mismatches++;
                    end
                    if (free_count !== exp.free)
                    begin
                        $error("free_count: expected %0d, actual %0d", exp.free, free_count);
                        mismatches++;
                    end
                end
                results_taken++;
                // One long hold-off so the block backs up and stalls its input.
                if (results_taken == HOLD_AT)
                begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= rst_n && !receiver_stalls();
            end
        end
    end

    // Stimulus: directed table first, then random traffic that fills, drains and mixes.
    initial
    begin
        int               items_sent;
        int               random_sent;
        int               mix_sent;
        int               brink;
        int               roll;
        tide_t            tide;
        func_t            op;
        logic [CNT_W-1:0] n;
        logic [PTR_W-1:0] level;

        directed_rows = '{
            '{FUNC_READ,  4'd1,  64'h0, 1'b1, '{1'b0, 64'h0, 11'd0, 11'd1024}},
            '{FUNC_PEEK,  4'd8,  64'h0, 1'b1, '{1'b0, 64'h0, 11'd0, 11'd1024}},
            '{FUNC_WRITE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b1, 64'h0, 11'd0, 11'd1024}},
            '{FUNC_WRITE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b1, 64'h0, 11'd8, 11'd1016}},
            '{FUNC_WRITE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b0, 64'h0, 11'd8, 11'd1016}},
            '{FUNC_WRITE, 4'd9,  64'h1234_5678_9ABC_DEF0, 1'b1,
              '{1'b0, 64'h0, 11'd8, 11'd1016}},
            '{FUNC_PEEK,  4'd8,  64'h0, 1'b1,
              '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 11'd8, 11'd1016}},
            '{FUNC_READ,  4'd0,  64'h0, 1'b1, '{1'b1, 64'h0, 11'd8, 11'd1016}},
            '{FUNC_PEEK,  4'd0,  64'h0, 1'b1, '{1'b1, 64'h0, 11'd8, 11'd1016}},
            '{FUNC_READ,  4'd3,  64'h0, 1'b1,
              '{1'b1, 64'h0000_0000_00FF_FFFF, 11'd5, 11'd1019}},
            '{FUNC_READ,  4'd9,  64'h0, 1'b1, '{1'b0, 64'h0, 11'd5, 11'd1019}},
            '{FUNC_PEEK,  4'd12, 64'h0, 1'b1, '{1'b0, 64'h0, 11'd5, 11'd1019}},
            '{FUNC_READ,  4'd6,  64'h0, 1'b1, '{1'b0, 64'h0, 11'd5, 11'd1019}},
            '{FUNC_WRITE, 4'd5,  64'h0123_4567_89AB_CDEF, 1'b0, '0},
            '{FUNC_PEEK,  4'd8,  64'h0, 1'b0, '0},
            '{FUNC_READ,  4'd8,  64'h0, 1'b0, '0},
            '{FUNC_CLEAR, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
              '{1'b1, 64'h0, 11'd0, 11'd1024}},
            '{FUNC_READ,  4'd1,  64'h0, 1'b1, '{1'b0, 64'h0, 11'd0, 11'd1024}},
            '{FUNC_WRITE, 4'd8,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
              '{1'b1, 64'h0, 11'd8, 11'd1016}},
            '{FUNC_WRITE, 4'd8,  64'h5555_5555_5555_5555, 1'b1,
              '{1'b1, 64'h0, 11'd16, 11'd1008}},
            '{FUNC_READ,  4'd8,  64'h0, 1'b1,
              '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 11'd8, 11'd1016}},
            '{FUNC_PEEK,  4'd4,  64'h0, 1'b1,
              '{1'b1, 64'h0000_0000_5555_5555, 11'd8, 11'd1016}},
            '{FUNC_READ,  4'd8,  64'h0, 1'b1,
              '{1'b1, 64'h5555_5555_5555_5555, 11'd0, 11'd1024}},
            '{FUNC_WRITE, 4'd1,  64'hF00D_CAFE_1234_5680, 1'b0, '0},
            '{FUNC_READ,  4'd1,  64'h0, 1'b0, '0}
        };

        items_sent = 0;
        random_sent = 0;
        mix_sent = 0;
        brink = 0;
        tide = TIDE_FILL;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_N; r++)
        begin
            idle_mode = idle_mode_t'((items_sent / MODE_SPAN) % 4);
            issue_op(directed_rows[r].op, directed_rows[r].n, directed_rows[r].wd,
                     directed_rows[r].typed, directed_rows[r].want);
            items_sent++;
        end

        // Fill to the brim, drain to empty, then a mixed stretch with clears.
        while (random_sent < RANDOM_ITEMS || tide != TIDE_MIX || mix_sent < MIX_MIN)
        begin
            idle_mode = idle_mode_t'((items_sent / MODE_SPAN) % 4);
            level = shadow_wr - shadow_rd;
            if (tide == TIDE_FILL && level > CAP - LANES)
            begin
                brink++;
            end
            else if (tide == TIDE_DRAIN && level < LANES)
            begin
                brink++;
            end
            if (brink >= BRINK_ITEMS)
            begin
                tide = (tide == TIDE_FILL) ? TIDE_DRAIN : TIDE_MIX;
                brink = 0;
            end

            roll = $urandom_range(99);
            case (tide)
                TIDE_FILL:
                    op = (roll < 90) ? FUNC_WRITE : (roll < 95) ? FUNC_READ : FUNC_PEEK;
                TIDE_DRAIN:
                    op = (roll < 88) ? FUNC_READ : (roll < 96) ? FUNC_PEEK : FUNC_WRITE;
                default:
                    op = (roll < 45) ? FUNC_WRITE : (roll < 80) ? FUNC_READ :
                         (roll < 95) ? FUNC_PEEK : FUNC_CLEAR;
            endcase

            // Mostly full-width transfers, with zero and oversized counts mixed in.
            roll = $urandom_range(99);
            if (roll < 5)
            begin
                n = '0;
            end
            else if (roll < 10)
            begin
                n = CNT_W'($urandom_range(15, LANES + 1));
            end
            else if (roll < 60)
            begin
                n = CNT_W'(LANES);
            end
            else
            begin
                n = CNT_W'($urandom_range(LANES, 1));
            end

            issue_op(op, n, {$urandom, $urandom}, 1'b0, '0);
            items_sent++;
            random_sent++;
            if (tide == TIDE_MIX)
            begin
                mix_sent++;
            end
        end
        in_valid <= 1'b0;

        while (awaited_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/brbf_pkg.sv
rtl/brbf_bank.sv
rtl/brbf_merge.sv
rtl/byte_ring_buffer_fifo.sv
rtl/brbf_checker.sv
tb/tb_top.sv
